@@ design/tutc_pkg.sv @@
// ----------------------------------------------------------------------------
// tutc_pkg
// Leap-second table, fixed-point constants and lookup helpers for the
// TAI to UTC / local time converter.
// ----------------------------------------------------------------------------
package tutc_pkg;

    localparam int LEAP_ENTRIES  = 28;
    localparam int ROM_LEN       = 28;
    localparam int LEAP_COUNT    = (LEAP_ENTRIES < ROM_LEN) ? LEAP_ENTRIES : ROM_LEN;
    localparam int TAI_EPOCH_MJD = 36204;

    typedef enum logic [0:0] {
        CFG_ZONE = 1'b0,
        CFG_DST  = 1'b1
    } cfg_index_t;

    localparam logic signed [63:0] LEAP_BOUNDARY [ROM_LEN] = '{
        64'sd441763200,  64'sd457488000,  64'sd473385600,  64'sd504921600,
        64'sd536457600,  64'sd567993600,  64'sd599616000,  64'sd631152000,
        64'sd662688000,  64'sd694224000,  64'sd741484800,  64'sd773020800,
        64'sd804556800,  64'sd867715200,  64'sd946684800,  64'sd1009843200,
        64'sd1041379200, 64'sd1088640000, 64'sd1120176000, 64'sd1151712000,
        64'sd1199145600, 64'sd1246406400, 64'sd1293840000, 64'sd1514764800,
        64'sd1609459200, 64'sd1719792000, 64'sd1814400000, 64'sd1861920000
    };

    localparam logic [5:0] LEAP_OFFSET [ROM_LEN] = '{
        6'd10, 6'd11, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
        6'd18, 6'd19, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
        6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd33,
        6'd34, 6'd35, 6'd36, 6'd37
    };

    localparam logic signed [63:0] S64_MAX   = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] DST_SHIFT = 64'sd3600;

    // 86400 = 128 * 675; quotient by 675 is taken 16 bits per digit
    localparam int          DAY_SHIFT   = 7;
    localparam int          DIGIT_W     = 16;
    localparam int          DIV_DIGITS  = 4;
    localparam int          DIV_STAGES  = 2 * DIV_DIGITS;
    localparam logic [25:0] DIV_DIGIT   = 26'd675;
    localparam logic [26:0] M675        = 27'd101806633;
    localparam int          M675_SHIFT  = 36;

    // bias so the dividend stays non-negative: 2^47 days
    localparam logic [64:0] DAY_BIAS = 65'd675 << 54;
    localparam logic [47:0] DAY_ADJ  = 48'(TAI_EPOCH_MJD) + (48'd1 << 47);

    localparam logic [17:0] M60        = 18'd139811;
    localparam int          M60_SHIFT  = 23;
    localparam logic [11:0] M60B       = 12'd2185;
    localparam int          M60B_SHIFT = 17;
    localparam logic [24:0] M108       = 25'd19884108;
    localparam int          M108_SHIFT = 31;

    function automatic logic signed [63:0] leap_threshold(input int idx);
        return LEAP_BOUNDARY[idx] + $signed({58'd0, LEAP_OFFSET[idx]});
    endfunction

    function automatic logic [5:0] lookup_offset(input logic signed [63:0] tai);
        logic [5:0] off;
        off = LEAP_OFFSET[0];
        for (int i = 0; i < LEAP_COUNT; i++)
        begin
            if (tai >= leap_threshold(i))
            begin
                off = LEAP_OFFSET[i];
            end
        end
        return off;
    endfunction

    function automatic logic is_inserted(input logic signed [63:0] tai);
        logic hit;
        hit = 1'b0;
        for (int i = 1; i < LEAP_COUNT; i++)
        begin
            if ((LEAP_OFFSET[i] == LEAP_OFFSET[i-1] + 6'd1) &&
                (tai == leap_threshold(i) - 64'sd1))
            begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

@@ design/tai_to_utc_leap_converter.sv @@
// ----------------------------------------------------------------------------
// tai_to_utc_leap_converter
// Converts TAI seconds to UTC or local wall time with leap-second handling,
// split into MJD day, hour, minute, second and day fraction.
// ----------------------------------------------------------------------------
//   channel | signals                                   | beat
//   in      | in_valid / in_ready                       | tai_count, mode
//   out     | out_valid / out_ready                     | wall time fields
//   cfg     | cfg_valid / cfg_ready (always ready)      | cfg_index, cfg_data
//
// One beat per cycle sustained while out_ready stays high; a beat reaches
// out_valid through 16 register stages (offset lookup, three 64-bit add stages,
// biased dividend, four 16-bit digit steps of the divide by 675 at two stages
// each, two time-of-day stages, output register).
// Reset clears all stage valids and the zone and DST registers.
// Each stage holds when the next one is full and stalled; empty stages fill.
module tai_to_utc_leap_converter
    import tutc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [63:0] tai_count,
    input  logic               mode,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [63:0] wall_seconds,
    output logic signed [47:0] day_number,
    output logic        [4:0]  hour,
    output logic        [5:0]  minute,
    output logic        [5:0]  second,
    output logic        [16:0] day_fraction,
    output logic               leap_flag,
    output logic               overflow,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic        [0:0]  cfg_index,
    input  logic        [16:0] cfg_data
);

    typedef struct packed {
        logic [63:0] wall;
        logic        ovf;
        logic        leap;
        logic [6:0]  low7;
        logic [63:0] t;
        logic [25:0] x;
        logic [15:0] q;
        logic [9:0]  rem;
        logic [63:0] quo;
    } div_t;

    logic signed [16:0] zone_reg;
    logic               dst_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_reg <= '0;
            dst_reg  <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ZONE: zone_reg <= cfg_data;
                CFG_DST:  dst_reg  <= cfg_data[0];
                default:  ;
            endcase
        end
    end

    // stage enables, back to front
    logic s1_en, s2_en, s3_en, s4_en, s5_en, t1_en, t2_en, o_en;
    logic div_en [DIV_STAGES];

    logic s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg, s5_v_reg;
    logic t1_v_reg, t2_v_reg, o_v_reg;
    logic div_v_reg [DIV_STAGES];

    assign o_en     = !o_v_reg || out_ready;
    assign t2_en    = !t2_v_reg || o_en;
    assign t1_en    = !t1_v_reg || t2_en;
    assign s5_en    = !s5_v_reg || div_en[0];
    assign s4_en    = !s4_v_reg || s5_en;
    assign s3_en    = !s3_v_reg || s4_en;
    assign s2_en    = !s2_v_reg || s3_en;
    assign s1_en    = !s1_v_reg || s2_en;
    assign in_ready = s1_en;

    // S1: leap table lookup
    logic signed [63:0] s1_tai_reg;
    logic               s1_mode_reg;
    logic        [5:0]  s1_off_reg;
    logic               s1_leap_reg;

    // S2: subtract TAI-UTC offset
    logic signed [63:0] s2_wall_reg;
    logic               s2_ovf_reg, s2_mode_reg, s2_leap_reg;
    logic        [64:0] s2_next;

    // S3: add zone offset, check DST headroom
    logic signed [63:0] s3_wall_reg;
    logic               s3_ovf_reg, s3_dst_reg, s3_leap_reg;
    logic        [65:0] s3_sum;
    logic        [65:0] s3_zone;
    logic               s3_ovf_next;

    // S4: DST shift
    logic signed [63:0] s4_wall_reg;
    logic               s4_ovf_reg, s4_leap_reg;

    // S5: biased dividend
    div_t               s5_reg;
    div_t               s5_next;
    logic        [64:0] s5_u;

    always_comb
    begin
        s2_next = {s1_tai_reg[63], s1_tai_reg} - {59'd0, s1_off_reg};
        s3_zone = s2_mode_reg ? {{49{zone_reg[16]}}, zone_reg} : 66'd0;
        s3_sum  = {{2{s2_wall_reg[63]}}, s2_wall_reg} + s3_zone;
        s3_ovf_next = s2_ovf_reg || (s3_sum[65:63] != 3'b000 && s3_sum[65:63] != 3'b111) ||
                      (s2_mode_reg && dst_reg &&
                       ($signed(s3_sum[63:0]) > (S64_MAX - DST_SHIFT)));
        s5_u = {s4_wall_reg[63], s4_wall_reg} - {64'd0, s4_leap_reg} + DAY_BIAS;
        s5_next      = '0;
        s5_next.wall = s4_wall_reg;
        s5_next.ovf  = s4_ovf_reg;
        s5_next.leap = s4_leap_reg;
        s5_next.low7 = s5_u[DAY_SHIFT-1:0];
        s5_next.t    = 64'(s5_u[64:DAY_SHIFT]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
            s5_v_reg <= 1'b0;
        end
        else
        begin
            if (s1_en) s1_v_reg <= in_valid;
            if (s2_en) s2_v_reg <= s1_v_reg;
            if (s3_en) s3_v_reg <= s2_v_reg;
            if (s4_en) s4_v_reg <= s3_v_reg;
            if (s5_en) s5_v_reg <= s4_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en)
        begin
            s1_tai_reg  <= tai_count;
            s1_mode_reg <= mode;
            s1_off_reg  <= lookup_offset(tai_count);
            s1_leap_reg <= is_inserted(tai_count);
        end
        if (s2_en)
        begin
            s2_wall_reg <= s2_next[63:0];
            s2_ovf_reg  <= s2_next[64] ^ s2_next[63];
            s2_mode_reg <= s1_mode_reg;
            s2_leap_reg <= s1_leap_reg;
        end
        if (s3_en)
        begin
            s3_wall_reg <= s3_sum[63:0];
            s3_ovf_reg  <= s3_ovf_next;
            s3_dst_reg  <= s2_mode_reg && dst_reg;
            s3_leap_reg <= s2_leap_reg;
        end
        if (s4_en)
        begin
            s4_wall_reg <= s3_wall_reg + (s3_dst_reg ? DST_SHIFT : 64'sd0);
            s4_ovf_reg  <= s3_ovf_reg;
            s4_leap_reg <= s3_leap_reg;
        end
        if (s5_en)
        begin
            s5_reg <= s5_next;
        end
    end

    // divide by 675, one 16-bit digit per stage pair (multiply, then remainder)
    div_t div_reg [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_div
        div_t        src;
        logic        src_v;
        div_t        nxt;
        logic [52:0] prod;

        if (k == 0)
        begin : g_first
            assign src   = s5_reg;
            assign src_v = s5_v_reg;
        end
        else
        begin : g_mid
            assign src   = div_reg[k-1];
            assign src_v = div_v_reg[k-1];
        end

        if (k == DIV_STAGES - 1)
        begin : g_last_en
            assign div_en[k] = !div_v_reg[k] || t1_en;
        end
        else
        begin : g_mid_en
            assign div_en[k] = !div_v_reg[k] || div_en[k+1];
        end

        if (k % 2 == 0)
        begin : g_mul
            always_comb
            begin
                nxt   = src;
                nxt.x = {src.rem, src.t[63 - DIGIT_W*(k/2) -: DIGIT_W]};
                prod  = 53'(nxt.x) * 53'(M675);
                nxt.q = prod[M675_SHIFT +: DIGIT_W];
            end
        end
        else
        begin : g_rem
            always_comb
            begin
                prod    = '0;
                nxt     = src;
                nxt.rem = 10'(src.x - 26'(src.q) * DIV_DIGIT);
                nxt.quo = {src.quo[63-DIGIT_W:0], src.q};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                div_v_reg[k] <= 1'b0;
            end
            else if (div_en[k])
            begin
                div_v_reg[k] <= src_v;
            end
        end

        always_ff @(posedge clk)
        begin
            if (div_en[k])
            begin
                div_reg[k] <= nxt;
            end
        end
    end

    // T1: second of day, minute count, fraction numerator, MJD
    div_t        div_last;
    logic [16:0] t1_r_next;
    logic [34:0] t1_m60_prod;

    logic [63:0] t1_wall_reg;
    logic        t1_ovf_reg, t1_leap_reg;
    logic [16:0] t1_r_reg;
    logic [10:0] t1_m60_reg;
    logic [23:0] t1_y_reg;
    logic [47:0] t1_day_reg;

    assign div_last    = div_reg[DIV_STAGES-1];
    assign t1_r_next   = {div_last.rem, div_last.low7};
    assign t1_m60_prod = 35'(t1_r_next) * 35'(M60);

    // T2: hour, second, fraction
    logic [22:0] t2_hr_prod;
    logic [48:0] t2_frac_prod;
    logic [16:0] t2_sec_full;

    logic [63:0] t2_wall_reg;
    logic        t2_ovf_reg, t2_leap_reg;
    logic [10:0] t2_m60_reg;
    logic [4:0]  t2_hr_reg;
    logic [5:0]  t2_sec_reg;
    logic [16:0] t2_frac_reg;
    logic [47:0] t2_day_reg;

    assign t2_hr_prod   = 23'(t1_m60_reg) * 23'(M60B);
    assign t2_frac_prod = 49'(t1_y_reg) * 49'(M108);
    assign t2_sec_full  = t1_r_reg - 17'(t1_m60_reg) * 17'd60;

    logic [10:0] o_min_full;
    assign o_min_full = t2_m60_reg - 11'(t2_hr_reg) * 11'd60;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_v_reg <= 1'b0;
            t2_v_reg <= 1'b0;
            o_v_reg  <= 1'b0;
        end
        else
        begin
            if (t1_en) t1_v_reg <= div_v_reg[DIV_STAGES-1];
            if (t2_en) t2_v_reg <= t1_v_reg;
            if (o_en)  o_v_reg  <= t2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (t1_en)
        begin
            t1_wall_reg <= div_last.wall;
            t1_ovf_reg  <= div_last.ovf;
            t1_leap_reg <= div_last.leap;
            t1_r_reg    <= t1_r_next;
            t1_m60_reg  <= t1_m60_prod[M60_SHIFT +: 11];
            t1_y_reg    <= 24'(t1_r_next) * 24'd125 + 24'd54;
            t1_day_reg  <= div_last.quo[47:0] + DAY_ADJ;
        end
        if (t2_en)
        begin
            t2_wall_reg <= t1_wall_reg;
            t2_ovf_reg  <= t1_ovf_reg;
            t2_leap_reg <= t1_leap_reg;
            t2_m60_reg  <= t1_m60_reg;
            t2_hr_reg   <= t2_hr_prod[M60B_SHIFT +: 5];
            t2_sec_reg  <= t2_sec_full[5:0];
            t2_frac_reg <= t2_frac_prod[M108_SHIFT +: 17];
            t2_day_reg  <= t1_day_reg;
        end
        if (o_en)
        begin
            overflow <= t2_ovf_reg;
            if (t2_ovf_reg)
            begin
                wall_seconds <= '0;
                day_number   <= '0;
                hour         <= '0;
                minute       <= '0;
                second       <= '0;
                day_fraction <= '0;
                leap_flag    <= 1'b0;
            end
            else
            begin
                wall_seconds <= t2_wall_reg;
                day_number   <= t2_day_reg;
                hour         <= t2_hr_reg;
                minute       <= o_min_full[5:0];
                second       <= t2_leap_reg ? 6'd60 : t2_sec_reg;
                day_fraction <= t2_frac_reg;
                leap_flag    <= t2_leap_reg;
            end
        end
    end

    assign out_valid = o_v_reg;

endmodule

@@ design/tutc_checker.sv @@
// ----------------------------------------------------------------------------
// tutc_checker
// Port-level checks for the TAI to UTC / local time converter.
// ----------------------------------------------------------------------------
module tutc_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [63:0] wall_seconds,
    input logic signed [47:0] day_number,
    input logic        [4:0]  hour,
    input logic        [5:0]  minute,
    input logic        [5:0]  second,
    input logic        [16:0] day_fraction,
    input logic               leap_flag,
    input logic               overflow
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(wall_seconds) &&
        $stable(day_number) && $stable(second) && $stable(overflow))
        else $error("result beat changed while stalled");

    a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |-> wall_seconds == 64'sd0 && day_number == 48'sd0 &&
        hour == 5'd0 && minute == 6'd0 && second == 6'd0 &&
        day_fraction == 17'd0 && !leap_flag)
        else $error("overflow beat carries nonzero fields");

    a_tod_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !overflow |-> hour < 5'd24 && minute < 6'd60 &&
        day_fraction < 17'd100000)
        else $error("time of day out of range");

    a_leap_sec: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !overflow |-> (leap_flag && second == 6'd60) ||
        (!leap_flag && second < 6'd60))
        else $error("second field disagrees with leap flag");

endmodule

bind tai_to_utc_leap_converter tutc_checker u_tutc_checker (.*);
